>>> rtl/swr_pkg.sv
// Shared types, widths and reset constants for the slew-guided wordlength reducer.
// Used by swr_front, swr_engine and the top level; depends on nothing.
package swr_pkg;

  // Default history depth and intake queue size
  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int QUEUE_DEPTH       = 2;
  localparam int LANES             = 2;

  // Field and register widths
  localparam int SAMPLE_W = 24;
  localparam int SCALE_W  = 40;
  localparam int SON_W    = 17;
  localparam int TAPS_W   = 7;
  localparam int GAIN_W   = 30;
  localparam int STEP_W   = 25;
  localparam int PROD_W   = 64;
  localparam int CFG_W    = 40;
  localparam int CIDX_W   = 2;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = 40'h80_0000_0000;
  localparam logic [SON_W-1:0]   SON_RST   = 17'd53019;
  localparam logic [TAPS_W-1:0]  TAPS_RST  = 7'd17;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 30'd512;

  // Step clamp: the floor candidate tops out one below the largest 25-bit value
  localparam logic signed [STEP_W-1:0] STEP_TOP = 25'sd16777215;
  localparam logic signed [STEP_W-1:0] STEP_MAX = 25'sd16777214;

  // Output saturation limits
  localparam logic signed [46:0] OUT_MAX = 47'sd8388607;
  localparam logic signed [46:0] OUT_MIN = -47'sd8388608;

  typedef enum logic [CIDX_W-1:0] {
    REG_SCALE    = 2'd0,
    REG_SONORITY = 2'd1,
    REG_DELAY    = 2'd2,
    REG_GAIN     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_factor;
    logic [SON_W-1:0]   sonority;
    logic [TAPS_W-1:0]  delay_taps;
    logic [GAIN_W-1:0]  output_gain;
  } cfg_t;

  // Stereo pair, left in the low bits
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } pair_t;

  // Head of the intake queue as seen by the engine
  typedef struct packed {
    logic  valid;
    pair_t data;
  } queue_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MHI,
    ST_QNT,
    ST_DIFF,
    ST_PICK
  } eng_state_t;

endpackage

>>> rtl/slew_guided_wordlength_reducer.sv
// Path: intake queue, engine sequence, product slot, then output register.
// The engine takes a new stereo pair only once its per-pair sequence is done
// (history read at the start, winner written back at the end).
// Reset: rst_n synchronous, active low; clears queue, sequencer, history valid
// bits (history reads as zero) and loads the register defaults.
// Top level: configuration registers, intake queue and engine; uses swr_pkg.
module slew_guided_wordlength_reducer
  import swr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // [23:0] left_in, [47:24] right_in
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // [23:0] left_out, [47:24] right_out
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t       cfg_r;
  queue_out_t q_head;
  logic       q_pop;
  pair_t      out_pair;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_factor <= SCALE_RST;
      cfg_r.sonority     <= SON_RST;
      cfg_r.delay_taps   <= TAPS_RST;
      cfg_r.output_gain  <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCALE:    cfg_r.scale_factor <= cfg_wdata[SCALE_W-1:0];
        REG_SONORITY: cfg_r.sonority     <= cfg_wdata[SON_W-1:0];
        REG_DELAY:    cfg_r.delay_taps   <= cfg_wdata[TAPS_W-1:0];
        REG_GAIN:     cfg_r.output_gain  <= cfg_wdata[GAIN_W-1:0];
        default:      cfg_r              <= cfg_r;
      endcase
    end
  end

  swr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pair   (pair_t'(in_tdata)),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  swr_engine #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pair   (out_pair)
  );

  assign out_tdata = out_pair;

endmodule

>>> rtl/swr_front.sv
// Intake side: a short queue of accepted stereo pairs ahead of the engine.
// Depends on swr_pkg.
module swr_front
  import swr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  pair_t      in_pair,
  output queue_out_t q_head,
  input  logic       q_pop
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  pair_t          entry_r [QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QW:0]    count_r, count_nxt;
  logic           push;

  assign in_tready = (count_r != (QW+1)'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + QW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + QW'(1);
    end
    count_nxt = count_r + (QW+1)'(push) - (QW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_pair;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.data  = entry_r[rd_ptr_r];

endmodule

>>> rtl/swr_engine.sv
// Back end: scales, quantizes against the slew history and renders one pair.
// Holds the history memory and the output register; depends on swr_pkg.
module swr_engine
  import swr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  queue_out_t q_head,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output pair_t      out_pair
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int TW = (AW > TAPS_W) ? AW : TAPS_W;
  localparam logic [TW-1:0] TAPS_LIM = TW'(HISTORY_DEPTH - 1);
  localparam logic [AW-1:0] HEAD_LAST = AW'(HISTORY_DEPTH - 1);
  localparam int HW = 2 * STEP_W;

  eng_state_t state_r, state_nxt;

  // Per-lane datapath registers
  logic signed [SAMPLE_W-1:0] x_r    [LANES];
  logic signed [44:0]         plo_r  [LANES];
  logic signed [PROD_W-1:0]   p_r    [LANES];
  logic signed [STEP_W-1:0]   qa_r   [LANES];
  logic [25:0]                aa_r   [LANES];
  logic [25:0]                ab_r   [LANES];
  logic [SCALE_W-1:0]         tgt_r  [LANES];
  logic [58:0]                da_r   [LANES];
  logic [58:0]                db_r   [LANES];
  logic                       big_r  [LANES];
  logic                       ltb_r  [LANES];
  logic signed [55:0]         prod_r [LANES];

  // History memory and its per-row valid bits
  logic [HW-1:0]            hist_mem [HISTORY_DEPTH];
  logic [HW-1:0]            hist_rd_r;
  logic                     hist_rv_r;
  logic [HISTORY_DEPTH-1:0] hvalid_r;
  logic [AW-1:0]            head_r;
  logic [AW-1:0]            rd_idx;
  logic                     hist_we;
  logic [HW-1:0]            hist_wdata;

  logic                     prod_valid_r, prod_move;
  logic                     out_valid_r;
  pair_t                    out_pair_r;

  logic signed [SAMPLE_W-1:0] x_in   [LANES];
  logic signed [STEP_W-1:0]   past   [LANES];
  logic signed [STEP_W-1:0]   winner [LANES];

  assign x_in[0] = q_head.data.left;
  assign x_in[1] = q_head.data.right;
  assign past[0] = hist_rv_r ? $signed(hist_rd_r[STEP_W-1:0])    : '0;
  assign past[1] = hist_rv_r ? $signed(hist_rd_r[HW-1:STEP_W])   : '0;

  // History read index: delay_taps (saturated) entries behind the last winner
  logic [TW-1:0]         taps_ext, taps_sat;
  logic signed [AW+1:0]  idx_dif;
  always_comb begin
    taps_ext = TW'(cfg.delay_taps);
    taps_sat = (taps_ext > TAPS_LIM) ? TAPS_LIM : taps_ext;
    idx_dif  = $signed({2'b00, head_r}) - $signed({2'b00, AW'(taps_sat)})
               - $signed((AW+2)'(1));
    if (idx_dif < 0) begin
      rd_idx = AW'(idx_dif + $signed((AW+2)'(HISTORY_DEPTH)));
    end else begin
      rd_idx = AW'(idx_dif);
    end
  end

  // Output stage hand-off
  assign prod_move = prod_valid_r && (!out_valid_r || out_tready);

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    hist_we   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_MHI;
        end
      end
      ST_MHI:  state_nxt = ST_QNT;
      ST_QNT:  state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_PICK;
      ST_PICK: begin
        if (!prod_valid_r || prod_move) begin
          hist_we   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Winner per lane
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (big_r[l] ? ltb_r[l] : (da_r[l] < db_r[l])) begin
        winner[l] = qa_r[l];
      end else begin
        winner[l] = qa_r[l] + STEP_W'(1);
      end
    end
    hist_wdata = {winner[1], winner[0]};
  end

  // Datapath, one step per sequencer state
  logic signed [44:0]       hprod  [LANES];
  logic signed [PROD_W-1:0] hi_ext [LANES];
  logic signed [PROD_W-1:0] lo_ext [LANES];
  logic signed [STEP_W-1:0] qa_fl  [LANES];
  logic signed [STEP_W-1:0] qa_c   [LANES];
  logic signed [25:0]       sa     [LANES];
  logic signed [25:0]       sb     [LANES];
  logic [PROD_W-1:0]        pmag   [LANES];
  logic [SCALE_W-1:0]       son39;
  logic [58:0]              ta     [LANES];
  logic [58:0]              tb     [LANES];
  logic [58:0]              tg     [LANES];

  always_comb begin
    son39 = {cfg.sonority, 23'b0};
    for (int l = 0; l < LANES; l++) begin
      hprod[l]  = x_r[l] * $signed({1'b0, cfg.scale_factor[SCALE_W-1:20]});
      hi_ext[l] = {hprod[l][43:0], 20'b0};
      lo_ext[l] = {{19{plo_r[l][44]}}, plo_r[l]};
      qa_fl[l]  = p_r[l][PROD_W-1:39];
      qa_c[l]   = (qa_fl[l] == STEP_TOP) ? STEP_MAX : qa_fl[l];
      sa[l]     = $signed({past[l][STEP_W-1], past[l]}) - $signed({qa_c[l][STEP_W-1], qa_c[l]});
      sb[l]     = sa[l] - 26'sd1;
      pmag[l]   = p_r[l][PROD_W-1] ? (~p_r[l] + PROD_W'(1)) : p_r[l];
      ta[l]     = {aa_r[l][19:0], 39'b0};
      tb[l]     = {ab_r[l][19:0], 39'b0};
      tg[l]     = {19'b0, tgt_r[l]};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (q_pop) begin
        x_r[l]   <= x_in[l];
        plo_r[l] <= x_in[l] * $signed({1'b0, cfg.scale_factor[19:0]});
      end
      if (state_r == ST_MHI) begin
        p_r[l] <= hi_ext[l] + lo_ext[l];
      end
      if (state_r == ST_QNT) begin
        qa_r[l] <= qa_c[l];
        aa_r[l] <= sa[l][25] ? 26'(-sa[l]) : 26'(sa[l]);
        ab_r[l] <= sb[l][25] ? 26'(-sb[l]) : 26'(sb[l]);
        if ((pmag[l][PROD_W-1:SCALE_W] != '0) || (pmag[l][SCALE_W-1:0] > son39)) begin
          tgt_r[l] <= son39;
        end else begin
          tgt_r[l] <= pmag[l][SCALE_W-1:0];
        end
      end
      if (state_r == ST_DIFF) begin
        big_r[l] <= (aa_r[l][25:20] != '0) || (ab_r[l][25:20] != '0);
        ltb_r[l] <= aa_r[l] < ab_r[l];
        da_r[l]  <= (ta[l] >= tg[l]) ? (ta[l] - tg[l]) : (tg[l] - ta[l]);
        db_r[l]  <= (tb[l] >= tg[l]) ? (tb[l] - tg[l]) : (tg[l] - tb[l]);
      end
      if (hist_we) begin
        prod_r[l] <= winner[l] * $signed({1'b0, cfg.output_gain});
      end
    end
  end

  // History memory: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[head_r] <= hist_wdata;
    end
    if (q_pop) begin
      hist_rd_r <= hist_mem[rd_idx];
    end
  end

  // History control: valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r  <= '0;
      hist_rv_r <= 1'b0;
      head_r    <= '0;
    end else begin
      if (q_pop) begin
        hist_rv_r <= hvalid_r[rd_idx];
      end
      if (hist_we) begin
        hvalid_r[head_r] <= 1'b1;
        head_r           <= (head_r == HEAD_LAST) ? '0 : head_r + AW'(1);
      end
    end
  end

  // Round half up, shift by 9, saturate to 24 bits
  logic signed [55:0] rsum [LANES];
  logic signed [46:0] rsh  [LANES];
  logic signed [SAMPLE_W-1:0] rsat [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rsum[l] = prod_r[l] + 56'sd256;
      rsh[l]  = rsum[l][55:9];
      if (rsh[l] > OUT_MAX) begin
        rsat[l] = OUT_MAX[SAMPLE_W-1:0];
      end else if (rsh[l] < OUT_MIN) begin
        rsat[l] = OUT_MIN[SAMPLE_W-1:0];
      end else begin
        rsat[l] = rsh[l][SAMPLE_W-1:0];
      end
    end
  end

  // Product slot and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (hist_we) begin
        prod_valid_r <= 1'b1;
      end else if (prod_move) begin
        prod_valid_r <= 1'b0;
      end
      if (prod_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_move) begin
      out_pair_r.left  <= rsat[0];
      out_pair_r.right <= rsat[1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_pair   = out_pair_r;

  // Checks
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE) && q_head.valid)
    else $error("queue popped outside idle or while empty");

  a_hist_marked: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |=> hvalid_r[$past(head_r)])
    else $error("history row not marked valid after write");

  a_prod_kept: assert property (@(posedge clk) disable iff (!rst_n)
    prod_valid_r && !prod_move |=> prod_valid_r)
    else $error("pending product lost");

  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIFF) |-> (qa_r[0] != STEP_TOP) && (qa_r[1] != STEP_TOP))
    else $error("floor candidate not clamped");

endmodule
